// ===== hdl/dqu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared types and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dqu_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;   // width of the value and data_out fields

    // operation codes (tuser of the input item)
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic shift_right;   // push front: every cell takes its left neighbor
        logic shift_left;    // pop front: every cell takes its right neighbor
        logic load_tail;     // push back: first empty cell loads the value
        logic drop_back;     // pop back: last held cell lets go
        logic clear;         // all cells empty
    } t_cell_cmd;

endpackage

// ===== hdl/dqu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqu_cell
// One slot of the queue chain: a word and a valid bit, shifted by neighbors.
// ----------------------------------------------------------------------------
module dqu_cell
    import dqu_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic                  i_prev_valid,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic                  i_next_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_back
);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_valid;
    logic                  w_tail;

    // held cells form a contiguous run from the front of the chain
    assign w_tail = ~r_valid & i_prev_valid;
    assign o_back = r_valid & ~i_next_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clear) begin
            r_valid <= 1'b0;
        end else if (i_cmd.shift_right) begin
            r_valid <= i_prev_valid;
        end else if (i_cmd.shift_left) begin
            r_valid <= i_next_valid;
        end else if (i_cmd.load_tail && w_tail) begin
            r_valid <= 1'b1;
        end else if (i_cmd.drop_back && o_back) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_right) begin
            r_data <= i_prev_data;
        end else if (i_cmd.shift_left) begin
            r_data <= i_next_data;
        end else if (i_cmd.load_tail && w_tail) begin
            r_data <= i_value;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== hdl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of signed words built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Each input item carries an operation in tuser (push back/front, pop
// back/front, read front/back, clear) and a 32-bit value in tdata, and
// produces exactly one result item: the value popped or read (zero
// otherwise), the element count after the operation, and a status (ok,
// empty on pop/read of an empty queue, full on push to a full queue; those
// leave the queue untouched). An item's result sits in the output register
// the cycle after it is taken, so one item per clock runs
// as long as the output side keeps taking results; apart from reset, the
// output register is the only thing that holds off the input. No clearing
// pass after reset.
//
// Storage is a row of DEPTH cells. The front always sits in cell 0: push
// front shifts the whole row one cell right, pop front shifts it left,
// push back loads the first empty cell and pop back empties the last held
// one. The back word is picked out by the one cell that flags itself as
// the back. Words are stored in DATA_WIDTH bits; results are sign-extended
// (or truncated) to 32 bits.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import dqu_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int OUT_W     = ((VALUE_W + CNT_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]   s_axis_tuser,   // [2:0] mode
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // data_out, count_out, zero pad
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    // ---------------- control state ----------------
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    // ---------------- output register ----------------
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_data;
    logic [CNT_W-1:0]    r_out_count;
    logic [STATUS_W-1:0] r_out_status;

    // ---------------- per-item decode ----------------
    logic                w_accept;
    logic                w_empty;
    logic                w_full;
    logic [MODE_W-1:0]   w_mode;
    logic signed [VALUE_W-1:0]    w_value;
    logic signed [DATA_WIDTH-1:0] w_push_word;
    t_cell_cmd           w_cmd_raw;
    t_cell_cmd           w_cmd;
    logic                w_sel_front;
    logic                w_sel_back;
    logic [VALUE_W-1:0]  w_res_data;
    logic [STATUS_W-1:0] w_res_status;

    // ---------------- chain ----------------
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_back;
    logic signed [DATA_WIDTH-1:0] w_front_word;
    logic signed [DATA_WIDTH-1:0] w_back_word;

    // no item is taken while reset is held
    assign s_axis_tready = i_rst_n & (~r_out_valid | m_axis_tready);
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    assign w_mode      = s_axis_tuser;
    assign w_value     = s_axis_tdata;
    // sign-extend or truncate the 32-bit value to the stored width
    assign w_push_word = DATA_WIDTH'(w_value);

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));

    // Operation decode. Refused operations leave the chain and count alone.
    always_comb begin
        w_cmd_raw    = '0;
        n_count      = r_count;
        w_sel_front  = 1'b0;
        w_sel_back   = 1'b0;
        w_res_status = STATUS_OK;
        unique case (w_mode)
            MODE_PUSH_BACK: begin
                if (w_full) begin
                    w_res_status = STATUS_FULL;
                end else begin
                    w_cmd_raw.load_tail = 1'b1;
                    n_count             = r_count + 1'b1;
                end
            end
            MODE_PUSH_FRONT: begin
                if (w_full) begin
                    w_res_status = STATUS_FULL;
                end else begin
                    w_cmd_raw.shift_right = 1'b1;
                    n_count               = r_count + 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (w_empty) begin
                    w_res_status = STATUS_EMPTY;
                end else begin
                    w_cmd_raw.drop_back = 1'b1;
                    w_sel_back          = 1'b1;
                    n_count             = r_count - 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (w_empty) begin
                    w_res_status = STATUS_EMPTY;
                end else begin
                    w_cmd_raw.shift_left = 1'b1;
                    w_sel_front          = 1'b1;
                    n_count              = r_count - 1'b1;
                end
            end
            MODE_READ_FRONT: begin
                if (w_empty) begin
                    w_res_status = STATUS_EMPTY;
                end else begin
                    w_sel_front = 1'b1;
                end
            end
            MODE_READ_BACK: begin
                if (w_empty) begin
                    w_res_status = STATUS_EMPTY;
                end else begin
                    w_sel_back = 1'b1;
                end
            end
            MODE_CLEAR: begin
                w_cmd_raw.clear = 1'b1;
                n_count         = '0;
            end
            default: begin
                // unused code: no effect
            end
        endcase
    end

    assign w_cmd = w_accept ? w_cmd_raw : '0;

    // Row of cells. Cell 0 is the front; its left feed is the push word,
    // always marked valid so an empty row has its tail at cell 0.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev_data;
        logic                  w_prev_valid;
        logic [DATA_WIDTH-1:0] w_next_data;
        logic                  w_next_valid;

        if (gi == 0) begin : g_first
            assign w_prev_data  = w_push_word;
            assign w_prev_valid = 1'b1;
        end else begin : g_inner_prev
            assign w_prev_data  = w_data[gi-1];
            assign w_prev_valid = w_valid[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner_next
            assign w_next_data  = w_data[gi+1];
            assign w_next_valid = w_valid[gi+1];
        end

        dqu_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_value      (w_push_word),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .o_data       (w_data[gi]),
            .o_valid      (w_valid[gi]),
            .o_back       (w_back[gi])
        );
    end

    assign w_front_word = w_data[0];

    // at most one cell flags itself as the back: AND-OR select
    always_comb begin
        w_back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_word = w_back_word | (w_back[i] ? w_data[i] : '0);
        end
    end

    always_comb begin
        if (w_sel_front) begin
            w_res_data = VALUE_W'(w_front_word);
        end else if (w_sel_back) begin
            w_res_data = VALUE_W'(w_back_word);
        end else begin
            w_res_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data   <= w_res_data;
            r_out_count  <= n_count;
            r_out_status <= w_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_count, r_out_data});
    assign m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    // count never goes past the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // held cells match the count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with count");

    // a full status only ever reports a full queue
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_FULL) |-> r_out_count == CNT_W'(DEPTH))
        else $error("full status with queue not full");

    // clear empties every cell
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_CLEAR) |=> (w_valid == '0 && r_count == '0))
        else $error("clear left cells held");
`endif

endmodule
